// ===== design/mvt_pkg.sv =====
// ----------------------------------------------------------------------------
// mvt_pkg: shared types and constants for the matrix-vector transform
// Widths, fixed-point format, item codes and stream packing offsets.
// ----------------------------------------------------------------------------
package mvt_pkg;

	localparam int FRAC_BITS = 16;             // fractional bits
	localparam int DATA_W    = 32;
	localparam int DIM       = 4;
	localparam int IDX_W     = $clog2(DIM);
	localparam int ENTRIES   = DIM * DIM;
	localparam int PROD_W    = 2 * DATA_W;
	localparam int SUM_W     = PROD_W + 2;     // four products, exact

	// input tdata layout, lowest bit first
	localparam int ROW_LSB   = 0;
	localparam int COL_LSB   = ROW_LSB + IDX_W;
	localparam int VAL_LSB   = COL_LSB + IDX_W;
	localparam int VEC_LSB   = VAL_LSB + DATA_W;
	localparam int S_USED_W  = VEC_LSB + DIM * DATA_W;
	localparam int S_TDATA_W = ((S_USED_W + 7) / 8) * 8;
	localparam int M_TDATA_W = DIM * DATA_W;

	typedef logic signed [DATA_W-1:0] entry_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef logic        [IDX_W-1:0]  idx_t;

	typedef entry_t [DIM-1:0]          vec_t;
	typedef prod_t  [DIM-1:0][DIM-1:0] prod_mat_t;
	typedef sum_t   [DIM-1:0]          sum_vec_t;
	typedef sum_t   [DIM-1:0][1:0]     pair_vec_t;

	typedef enum logic {
		ACT_LOAD  = 1'b0,
		ACT_XFORM = 1'b1
	} action_t;

	localparam entry_t ENTRY_ONE = entry_t'(64'sd1 <<< FRAC_BITS);
	localparam sum_t   ROUND_HALF = sum_t'(1) <<< (FRAC_BITS - 1);
	localparam entry_t OUT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam entry_t OUT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

endpackage

// ===== design/mvt_mult_stage.sv =====
// ----------------------------------------------------------------------------
// mvt_mult_stage: matrix store and sixteen-product stage
// Holds the matrix (identity after reset), applies entry loads and
// registers all entry-by-component products of a transform item.
// ----------------------------------------------------------------------------
module mvt_mult_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_accept,
	input  mvt_pkg::action_t    action,
	input  mvt_pkg::idx_t       entry_row,
	input  mvt_pkg::idx_t       entry_col,
	input  mvt_pkg::entry_t     entry_value,
	input  mvt_pkg::vec_t       vec,
	input  logic                ready_s1,
	output logic                valid_s1,
	output mvt_pkg::prod_mat_t  prod_s1
);
	import mvt_pkg::*;

	entry_t mat_q [ENTRIES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				mat_q[i] <= ((i / DIM) == (i % DIM)) ? ENTRY_ONE : '0;
			end
		end else if (in_accept && action == ACT_LOAD) begin
			mat_q[{entry_row, entry_col}] <= entry_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_accept && action == ACT_XFORM;
		end
	end

	// products from the matrix as it stands before this edge
	always_ff @(posedge clk) begin
		if (ready_s1) begin
			for (int r = 0; r < DIM; r++) begin
				for (int c = 0; c < DIM; c++) begin
					prod_s1[r][c] <= prod_t'($signed(mat_q[r*DIM+c])) *
						prod_t'($signed(vec[c]));
				end
			end
		end
	end

endmodule

// ===== design/mvt_adder_tree.sv =====
// ----------------------------------------------------------------------------
// mvt_adder_tree: two-level registered row sums
// Stage 2 adds product pairs (rounding half folded in), stage 3 the pairs.
// ----------------------------------------------------------------------------
module mvt_adder_tree (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_s1,
	input  mvt_pkg::prod_mat_t  prod_s1,
	input  logic                ready_s2,
	input  logic                ready_s3,
	output logic                valid_s2,
	output logic                valid_s3,
	output mvt_pkg::sum_vec_t   sum_s3
);
	import mvt_pkg::*;

	pair_vec_t pair_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2) begin
			for (int r = 0; r < DIM; r++) begin
				pair_s2[r][0] <= sum_t'($signed(prod_s1[r][0])) +
					sum_t'($signed(prod_s1[r][1]));
				pair_s2[r][1] <= sum_t'($signed(prod_s1[r][2])) +
					sum_t'($signed(prod_s1[r][3])) + ROUND_HALF;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3) begin
			for (int r = 0; r < DIM; r++) begin
				sum_s3[r] <= $signed(pair_s2[r][0]) + $signed(pair_s2[r][1]);
			end
		end
	end

endmodule

// ===== design/mvt_round_sat.sv =====
// ----------------------------------------------------------------------------
// mvt_round_sat: scale, saturate and output register
// Drops the fraction bits of the rounded sums, clamps to 32 bits, flags it.
// ----------------------------------------------------------------------------
module mvt_round_sat (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_s3,
	input  mvt_pkg::sum_vec_t  sum_s3,
	input  logic               ready_s4,
	output logic               valid_s4,
	output mvt_pkg::vec_t      res_s4,
	output logic               clip_s4
);
	import mvt_pkg::*;

	localparam int TOP_LSB = FRAC_BITS + DATA_W - 1;

	vec_t            res_d;
	logic [DIM-1:0]  clip_d;

	always_comb begin
		for (int r = 0; r < DIM; r++) begin
			// bits above the result must all repeat its sign
			if (&sum_s3[r][SUM_W-1:TOP_LSB] || ~|sum_s3[r][SUM_W-1:TOP_LSB]) begin
				res_d[r]  = sum_s3[r][TOP_LSB:FRAC_BITS];
				clip_d[r] = 1'b0;
			end else begin
				res_d[r]  = sum_s3[r][SUM_W-1] ? OUT_MIN : OUT_MAX;
				clip_d[r] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (ready_s4) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s4) begin
			res_s4  <= res_d;
			clip_s4 <= |clip_d;
		end
	end

endmodule

// ===== design/matrix_vector_transform.sv =====
// ----------------------------------------------------------------------------
// matrix_vector_transform: 4x4 fixed-point matrix times 4-vector
// Signed Q16.16 matrix (identity after reset), per-entry loads, saturated
// row dot products with a clip flag, four-stage pipeline.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                                  | tuser
//  s_*     | in  | row, col, entry value, x, y, z, w      | action (0 load, 1 xform)
//  m_*     | out | out_x, out_y, out_z, out_w             | clipped
//
//  One item per cycle sustained while m_tready stays high. A transform result
//  passes the product stage, pair-sum stage, row-sum stage, then the
//  scale/saturate output register. A load takes effect for the next item.
//  Reset clears all stage valid bits and puts the identity in the matrix.
//  A stall on m_tready backs up stage by stage; bubbles are squeezed out,
//  and s_tready drops only when all four stages hold items.
// ----------------------------------------------------------------------------
module matrix_vector_transform (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [1:0] entry_row, [3:2] entry_col, [35:4] entry_value, [67:36] vec_x,
	// [99:68] vec_y, [131:100] vec_z, [163:132] vec_w, rest zero
	input  logic [mvt_pkg::S_TDATA_W-1:0]     s_tdata,
	// [0] action
	input  logic                              s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [31:0] out_x, [63:32] out_y, [95:64] out_z, [127:96] out_w
	output logic [mvt_pkg::M_TDATA_W-1:0]     m_tdata,
	// [0] clipped
	output logic                              m_tuser
);
	import mvt_pkg::*;

	logic      in_accept;
	action_t   action;
	vec_t      vec;
	logic      valid_s1, valid_s2, valid_s3, valid_s4;
	logic      ready_s1, ready_s2, ready_s3, ready_s4;
	prod_mat_t prod_s1;
	sum_vec_t  sum_s3;
	vec_t      res_s4;
	logic      clip_s4;

	// each stage moves when empty or when the one after it moves
	assign ready_s4 = !valid_s4 || m_tready;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;

	assign s_tready  = ready_s1;
	assign in_accept = s_tvalid && s_tready;
	assign action    = action_t'(s_tuser);

	always_comb begin
		for (int c = 0; c < DIM; c++) begin
			vec[c] = s_tdata[VEC_LSB + c*DATA_W +: DATA_W];
		end
	end

	mvt_mult_stage u_mult (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_accept   (in_accept),
		.action      (action),
		.entry_row   (s_tdata[ROW_LSB +: IDX_W]),
		.entry_col   (s_tdata[COL_LSB +: IDX_W]),
		.entry_value (s_tdata[VAL_LSB +: DATA_W]),
		.vec         (vec),
		.ready_s1    (ready_s1),
		.valid_s1    (valid_s1),
		.prod_s1     (prod_s1)
	);

	mvt_adder_tree u_tree (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.prod_s1  (prod_s1),
		.ready_s2 (ready_s2),
		.ready_s3 (ready_s3),
		.valid_s2 (valid_s2),
		.valid_s3 (valid_s3),
		.sum_s3   (sum_s3)
	);

	mvt_round_sat u_sat (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s3 (valid_s3),
		.sum_s3   (sum_s3),
		.ready_s4 (ready_s4),
		.valid_s4 (valid_s4),
		.res_s4   (res_s4),
		.clip_s4  (clip_s4)
	);

	assign m_tvalid = valid_s4;
	assign m_tdata  = res_s4;
	assign m_tuser  = clip_s4;

`ifndef NO_ASSERTIONS
	// input backpressure only when the whole pipe is full and blocked
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4 && !m_tready))
		else $error("s_tready low with room in the pipeline");

	// a blocked row-sum stage keeps its item
	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && !ready_s3) |=> (valid_s3 && $stable(sum_s3)))
		else $error("stage 3 item changed while stalled");

	// a clipped result has at least one component pinned at a rail
	a_clip_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |->
			(res_s4[0] == OUT_MAX || res_s4[0] == OUT_MIN ||
			 res_s4[1] == OUT_MAX || res_s4[1] == OUT_MIN ||
			 res_s4[2] == OUT_MAX || res_s4[2] == OUT_MIN ||
			 res_s4[3] == OUT_MAX || res_s4[3] == OUT_MIN))
		else $error("clip flag without a saturated component");
`endif

endmodule

// ===== sim/matrix_vector_transform_test.sv =====
// ----------------------------------------------------------------------------
// matrix_vector_transform_test: self-checking bench for the 4x4 transform
// Streams matrix loads and vector transforms through the block with random
// gaps on both sides. A matrix copy kept here predicts every transform, and
// each output item is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module matrix_vector_transform_test;

	timeunit 1ns;
	timeprecision 1ps;

	import mvt_pkg::*;

	localparam int RANDOM_ITEMS = 950;
	localparam int IDLE_PCT     = 35;
	localparam int HOLD_CYCLES  = 80;   // long receiver hold-off, fills the pipe
	localparam int HOLD_AT      = 100;  // results seen before the hold-off starts
	localparam int SETTLE       = 16;   // pipeline is four deep; margin on top
	localparam int MAX_REPORTS  = 10;

	// one item queued for the sender
	typedef struct {
		action_t act;
		idx_t    row;
		idx_t    col;
		entry_t  value;
		vec_t    vec;
		bit      drain;    // sender waits for all outstanding results first
	} stim_item_t;

	// one transform result
	typedef struct {
		vec_t comp;
		logic clipped;
	} xform_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic                 s_tuser = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tuser;

	stim_item_t pending_items[$];
	xform_t     awaited_results[$];
	entry_t     mat_now[DIM][DIM];    // matrix as the block should hold it

	bit took_item = 1'b0;             // input handshake seen at the last rising edge
	int items_sent = 0;
	int results_seen = 0;
	int mismatches = 0;
	int hold_left = 0;
	bit held_once = 1'b0;

	matrix_vector_transform dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// --------------------------------------------------------------------
	// Prediction: exact sum of four products, round half up, then clamp.
	// --------------------------------------------------------------------
	function automatic xform_t apply_matrix(input vec_t v);
		xform_t             r;
		logic signed [65:0] acc;
		logic signed [65:0] a;
		logic signed [65:0] b;
		r.clipped = 1'b0;
		for (int row = 0; row < DIM; row++) begin
			acc = '0;
			for (int col = 0; col < DIM; col++) begin
				a = mat_now[row][col];
				b = v[col];
				acc = acc + a * b;
			end
			acc = (acc + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
			if (acc > 66'sd2147483647) begin
				r.comp[row] = OUT_MAX;
				r.clipped = 1'b1;
			end else if (acc < -66'sd2147483648) begin
				r.comp[row] = OUT_MIN;
				r.clipped = 1'b1;
			end else begin
				r.comp[row] = acc[DATA_W-1:0];
			end
		end
		return r;
	endfunction

	// Mostly modest fixed-point values, with the edges of the range mixed in.
	function automatic entry_t pick_word(input int spread);
		int span;
		span = 1 << spread;
		case ($urandom_range(0, 11))
			0: return OUT_MIN;
			1: return OUT_MAX;
			2: return '0;
			3: return ENTRY_ONE;
			4: return -ENTRY_ONE;
			5, 6: return entry_t'($urandom);
			default: return entry_t'(int'($urandom_range(0, 2 * span)) - span);
		endcase
	endfunction

	function automatic vec_t pick_vec();
		vec_t v;
		for (int i = 0; i < DIM; i++)
			v[i] = pick_word(24);
		return v;
	endfunction

	function automatic vec_t noise_vec();
		vec_t v;
		for (int i = 0; i < DIM; i++)
			v[i] = entry_t'($urandom);
		return v;
	endfunction

	// Loads carry junk in the vector fields, transforms junk in the entry
	// fields: the block must ignore both.
	task automatic add_load(input int row, input int col, input entry_t value);
		stim_item_t c;
		c.act   = ACT_LOAD;
		c.row   = idx_t'(row);
		c.col   = idx_t'(col);
		c.value = value;
		c.vec   = noise_vec();
		c.drain = 1'b0;
		pending_items.push_back(c);
	endtask

	task automatic add_xform(input vec_t v);
		stim_item_t c;
		c.act   = ACT_XFORM;
		c.row   = idx_t'($urandom_range(0, DIM - 1));
		c.col   = idx_t'($urandom_range(0, DIM - 1));
		c.value = entry_t'($urandom);
		c.vec   = v;
		c.drain = 1'b0;
		pending_items.push_back(c);
	endtask

	// --------------------------------------------------------------------
	// Rising edge: check output items, then fold accepted inputs into the
	// matrix copy / prediction queue. Output is checked first; the block's
	// latency keeps an input from showing up in the same cycle anyway.
	// --------------------------------------------------------------------
	always @(posedge clk) begin : observe
		xform_t want;
		xform_t got;
		logic   bad;
		took_item = 1'b0;
		if (!arst_n) begin
			for (int r = 0; r < DIM; r++)
				for (int c = 0; c < DIM; c++)
					mat_now[r][c] = (r == c) ? ENTRY_ONE : '0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				got.comp    = vec_t'(m_tdata);
				got.clipped = m_tuser;
				if (awaited_results.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: result with nothing awaited: %h clip %b",
							$realtime, got.comp, got.clipped);
				end else begin
					want = awaited_results.pop_front();
					bad = (got.clipped !== want.clipped);
					for (int i = 0; i < DIM; i++)
						if (got.comp[i] !== want.comp[i])
							bad = 1'b1;
					if (bad) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS) begin
							$display("%0t: result mismatch", $realtime);
							$display("  expected x %h y %h z %h w %h clip %b",
								want.comp[0], want.comp[1], want.comp[2], want.comp[3],
								want.clipped);
							$display("  actual   x %h y %h z %h w %h clip %b",
								got.comp[0], got.comp[1], got.comp[2], got.comp[3],
								got.clipped);
						end
					end
				end
			end
			if (s_tvalid && s_tready) begin
				took_item = 1'b1;
				if (action_t'(s_tuser) == ACT_LOAD)
					mat_now[s_tdata[ROW_LSB +: IDX_W]][s_tdata[COL_LSB +: IDX_W]] =
						entry_t'(s_tdata[VAL_LSB +: DATA_W]);
				else
					awaited_results.push_back(
						apply_matrix(vec_t'(s_tdata[VEC_LSB +: DIM * DATA_W])));
			end
		end
	end

	// --------------------------------------------------------------------
	// Sender: drives on the falling edge. Holds an item until taken, idles
	// at random except in a calm window, and stops at drain marks until
	// every outstanding result is back.
	// --------------------------------------------------------------------
	always @(negedge clk) begin : drive
		stim_item_t           c;
		logic                 nxt_valid;
		logic [S_TDATA_W-1:0] nxt_data;
		logic                 nxt_user;
		bit                   calm;
		nxt_valid = s_tvalid;
		nxt_data  = s_tdata;
		nxt_user  = s_tuser;
		calm = (items_sent >= 450 && items_sent < 600);
		if (!arst_n) begin
			nxt_valid = 1'b0;
		end else if (!s_tvalid || took_item) begin
			nxt_valid = 1'b0;
			for (int i = 0; i < S_TDATA_W; i += 8)
				nxt_data[i +: 8] = 8'($urandom);
			nxt_data[S_TDATA_W-1:S_USED_W] = '0;
			nxt_user = 1'($urandom_range(0, 1));
			if (pending_items.size() != 0
					&& !(pending_items[0].drain && awaited_results.size() != 0)
					&& (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
				c = pending_items.pop_front();
				nxt_data = '0;
				nxt_data[ROW_LSB +: IDX_W]        = c.row;
				nxt_data[COL_LSB +: IDX_W]        = c.col;
				nxt_data[VAL_LSB +: DATA_W]       = c.value;
				nxt_data[VEC_LSB +: DIM * DATA_W] = c.vec;
				nxt_user  = c.act;
				nxt_valid = 1'b1;
				items_sent++;
			end
		end
		s_tvalid <= nxt_valid;
		s_tdata  <= nxt_data;
		s_tuser  <= nxt_user;
	end

	// --------------------------------------------------------------------
	// Receiver: random back-pressure, one long hold-off so the pipe fills
	// and s_tready drops, and a calm stretch with no stalls.
	// --------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (!held_once && results_seen >= HOLD_AT) begin
			held_once = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			m_tready <= 1'b0;
		end else if (results_seen >= 300 && results_seen < 420) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// --------------------------------------------------------------------
	// Stimulus and end of run
	// --------------------------------------------------------------------
	initial begin
		int   directed;
		vec_t v;

		// identity after reset, extreme and small components
		v = '{-1, 0, OUT_MAX, OUT_MIN};              // x..w = MIN, MAX, 0, -1
		add_xform(v);
		v = '{32'sh8000, 1, -ENTRY_ONE, ENTRY_ONE};
		add_xform(v);
		// positive saturation on row 0
		add_load(0, 0, OUT_MAX);
		add_load(0, 1, OUT_MAX);
		v = '{0, 0, OUT_MAX, OUT_MAX};
		add_xform(v);
		// negative entry: both clamp directions
		add_load(1, 1, OUT_MIN);
		v = '{0, 0, OUT_MIN, OUT_MIN};
		add_xform(v);
		v = '{0, 0, OUT_MAX, 0};
		add_xform(v);
		// exact half-LSB ties round toward plus infinity
		add_load(3, 3, 1);
		add_load(2, 2, -1);
		v = '{32'sh8000, 32'sh8000, 0, 0};
		add_xform(v);
		v = '{-32'sh8000, -32'sh8000, 0, 0};
		add_xform(v);
		// last row and column indexes
		add_load(3, 0, ENTRY_ONE);
		add_load(3, 1, -ENTRY_ONE);
		add_load(3, 2, 0);
		add_load(2, 3, OUT_MIN);
		v = '{-1, -1, -1, -1};
		add_xform(v);
		add_xform(noise_vec());
		directed = pending_items.size();

		// random part: single loads, single transforms, whole-matrix rewrites
		// followed by four columns (a matrix product), and row rewrites
		while (pending_items.size() < directed + RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0, 1, 2: add_load($urandom_range(0, DIM - 1), $urandom_range(0, DIM - 1),
					pick_word(18));
				3, 4, 5, 6: add_xform(pick_vec());
				7: begin
					for (int r = 0; r < DIM; r++)
						for (int c = 0; c < DIM; c++)
							add_load(r, c, pick_word(18));
					for (int c = 0; c < DIM; c++)
						add_xform(pick_vec());
				end
				default: begin
					begin
						int r;
						r = $urandom_range(0, DIM - 1);
						for (int c = 0; c < DIM; c++)
							add_load(r, c, pick_word(18));
					end
					add_xform(pick_vec());
				end
			endcase
		end
		// sender pauses until the pipe is empty at these items
		pending_items[300].drain = 1'b1;
		pending_items[700].drain = 1'b1;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() != 0 || s_tvalid)
			@(posedge clk);
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		if (mismatches == 0 && awaited_results.size() == 0)
			$display("** matrix_vector_transform: PASSED **");
		else
			$display("** matrix_vector_transform: FAILED **");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("** matrix_vector_transform: FAILED **");
		$finish;
	end

endmodule

// ===== sim.f =====
design/mvt_pkg.sv
design/mvt_mult_stage.sv
design/mvt_adder_tree.sv
design/mvt_round_sat.sv
design/matrix_vector_transform.sv
sim/matrix_vector_transform_test.sv
